>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LEBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lebm assertion failed");

// Next-cycle implication, disabled in reset.
`define LEBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lebm assertion failed");

`endif

>>> hw/rtl/lebm_pkg.sv
// Shared constants and controller/datapath interface types for the line extent block.
package lebm_pkg;

  localparam int ROW_BITS   = 12;
  localparam int HIST_BITS  = ROW_BITS + 1;
  localparam int HIST_DEPTH = 1 << HIST_BITS;
  localparam int CNT_W      = 12;
  localparam int MAX_BOXES  = 1024;
  localparam int BOX_W      = $clog2(MAX_BOXES + 1);
  localparam int TAG_W      = 8;
  localparam int ENTRY_W    = TAG_W + CNT_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic accept;
    logic update;
    logic clear;
  } lebm_cmd_t;

  typedef struct packed {
    logic last;
    logic tag_full;
    logic clear_end;
  } lebm_sts_t;

endpackage

>>> hw/rtl/lebm_ctrl.sv
// Controller state machine: memory clearing pass, box accept and histogram update sequencing.
module lebm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lebm_pkg::lebm_sts_t sts,
  output lebm_pkg::lebm_cmd_t cmd
);
  import lebm_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clear_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (sts.last && sts.tag_full) begin
          state_nxt = S_CLEAR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy       = busy_r;
  assign cmd.accept = start && (state_r == S_IDLE);
  assign cmd.update = (state_r == S_UPDATE);
  assign cmd.clear  = (state_r == S_CLEAR);

endmodule

>>> hw/rtl/lebm_datapath.sv
// Datapath: tagged bottom-row histogram memory, running extents, best row and result registers.
module lebm_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lebm_pkg::lebm_cmd_t            cmd,
  output lebm_pkg::lebm_sts_t            sts,
  input  logic [lebm_pkg::ROW_BITS-1:0]  in_box_top,
  input  logic [lebm_pkg::ROW_BITS-1:0]  in_box_height,
  input  logic                           in_last_box,
  output logic                           out_valid,
  output logic [lebm_pkg::ROW_BITS-1:0]  out_line_top,
  output logic [lebm_pkg::HIST_BITS-1:0] out_line_bottom,
  output logic [lebm_pkg::HIST_BITS-1:0] out_baseline_row,
  output logic [lebm_pkg::BOX_W-1:0]     out_box_count
);
  import lebm_pkg::*;

  logic [ENTRY_W-1:0]   hist_mem [HIST_DEPTH];
  logic [ENTRY_W-1:0]   rd_r;

  logic [HIST_BITS-1:0] bottom_in;
  logic [HIST_BITS-1:0] bot_r;
  logic [ROW_BITS-1:0]  top_r;
  logic                 last_r;

  logic [TAG_W-1:0]     tag_r;
  logic [HIST_BITS-1:0] clr_addr_r;
  logic [ROW_BITS-1:0]  top_min_r;
  logic [HIST_BITS-1:0] bot_max_r;
  logic [HIST_BITS-1:0] best_row_r;
  logic [CNT_W-1:0]     best_cnt_r;
  logic [BOX_W-1:0]     boxes_r;
  logic                 out_valid_r;

  logic [ROW_BITS-1:0]  line_top_r;
  logic [HIST_BITS-1:0] line_bottom_r;
  logic [HIST_BITS-1:0] baseline_r;
  logic [BOX_W-1:0]     box_count_r;

  logic [TAG_W-1:0]     rd_tag;
  logic [CNT_W-1:0]     rd_cnt;
  logic [CNT_W-1:0]     cnt_old;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 take_best;
  logic [ROW_BITS-1:0]  top_min_nxt;
  logic [HIST_BITS-1:0] bot_max_nxt;
  logic [HIST_BITS-1:0] best_row_nxt;
  logic [CNT_W-1:0]     best_cnt_nxt;
  logic [BOX_W-1:0]     boxes_nxt;

  logic                 mem_we;
  logic [HIST_BITS-1:0] mem_wa;
  logic [ENTRY_W-1:0]   mem_wd;

  assign bottom_in = HIST_BITS'(in_box_top) + HIST_BITS'(in_box_height);

  assign rd_tag  = rd_r[ENTRY_W-1:CNT_W];
  assign rd_cnt  = rd_r[CNT_W-1:0];
  assign cnt_old = (rd_tag == tag_r) ? rd_cnt : '0;
  assign cnt_nxt = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + CNT_W'(1);

  assign take_best    = (cnt_nxt > best_cnt_r) ||
                        ((cnt_nxt == best_cnt_r) && (bot_r < best_row_r));
  assign best_row_nxt = take_best ? bot_r : best_row_r;
  assign best_cnt_nxt = take_best ? cnt_nxt : best_cnt_r;
  assign top_min_nxt  = (top_r < top_min_r) ? top_r : top_min_r;
  assign bot_max_nxt  = (bot_r > bot_max_r) ? bot_r : bot_max_r;
  assign boxes_nxt    = (boxes_r < BOX_W'(MAX_BOXES)) ? boxes_r + BOX_W'(1) : boxes_r;

  assign mem_we = cmd.update || cmd.clear;
  assign mem_wa = cmd.clear ? clr_addr_r : bot_r;
  assign mem_wd = cmd.clear ? '0 : {tag_r, cnt_nxt};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
    if (cmd.accept) begin
      rd_r <= hist_mem[bottom_in];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bot_r  <= bottom_in;
      top_r  <= in_box_top;
      last_r <= in_last_box;
    end
    if (cmd.update && last_r) begin
      line_top_r    <= top_min_nxt;
      line_bottom_r <= bot_max_nxt;
      baseline_r    <= best_row_nxt;
      box_count_r   <= boxes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= '0;
      clr_addr_r  <= '0;
      top_min_r   <= '1;
      bot_max_r   <= '0;
      best_row_r  <= '0;
      best_cnt_r  <= '0;
      boxes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update && last_r;
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + HIST_BITS'(1);
        if (&clr_addr_r) begin
          tag_r <= TAG_W'(1);
        end
      end
      if (cmd.update) begin
        if (last_r) begin
          tag_r      <= tag_r + TAG_W'(1);
          top_min_r  <= '1;
          bot_max_r  <= '0;
          best_row_r <= '0;
          best_cnt_r <= '0;
          boxes_r    <= '0;
        end else begin
          top_min_r  <= top_min_nxt;
          bot_max_r  <= bot_max_nxt;
          best_row_r <= best_row_nxt;
          best_cnt_r <= best_cnt_nxt;
          boxes_r    <= boxes_nxt;
        end
      end
    end
  end

  assign sts.last      = last_r;
  assign sts.tag_full  = &tag_r;
  assign sts.clear_end = &clr_addr_r;

  assign out_valid        = out_valid_r;
  assign out_line_top     = line_top_r;
  assign out_line_bottom  = line_bottom_r;
  assign out_baseline_row = baseline_r;
  assign out_box_count    = box_count_r;

endmodule

>>> hw/rtl/line_extent_and_baseline_mode.sv
// Line extent and baseline finder: per box, a histogram read, then a histogram update/write.
// No new box is taken before the last one is written; the strobe follows the last box's update.
// Throughput is set by the single-port read-modify-write of the 8192-entry histogram memory.
// After reset, and after every 255th line, busy stays high for a clearing pass of all 8192 entries.
// Reset is synchronous, active low; results are strobed for one cycle and are never held off.
module line_extent_and_baseline_mode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [lebm_pkg::ROW_BITS-1:0]  in_box_top,
  input  logic [lebm_pkg::ROW_BITS-1:0]  in_box_height,
  input  logic                           in_last_box,
  output logic                           out_valid,
  output logic [lebm_pkg::ROW_BITS-1:0]  out_line_top,
  output logic [lebm_pkg::HIST_BITS-1:0] out_line_bottom,
  output logic [lebm_pkg::HIST_BITS-1:0] out_baseline_row,
  output logic [lebm_pkg::BOX_W-1:0]     out_box_count
);
  import lebm_pkg::*;

  `include "assert_macros.svh"

  lebm_cmd_t cmd;
  lebm_sts_t sts;

  lebm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lebm_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_box_top       (in_box_top),
    .in_box_height    (in_box_height),
    .in_last_box      (in_last_box),
    .out_valid        (out_valid),
    .out_line_top     (out_line_top),
    .out_line_bottom  (out_line_bottom),
    .out_baseline_row (out_baseline_row),
    .out_box_count    (out_box_count)
  );

  `LEBM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `LEBM_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `LEBM_ASSERT_IMPLY(a_count_nonzero, clk, rst_n, out_valid, out_box_count != '0)
  `LEBM_ASSERT_IMPLY(a_base_in_line, clk, rst_n, out_valid, out_baseline_row <= out_line_bottom)

endmodule

>>> tb/sv/line_summary_compare.sv
// Predicts line extent and baseline summaries from accepted box words and compares DUT results.
module line_summary_compare (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [lebm_pkg::ROW_BITS-1:0]  in_box_top,
  input  logic [lebm_pkg::ROW_BITS-1:0]  in_box_height,
  input  logic                           in_last_box,
  input  logic                           out_valid,
  input  logic [lebm_pkg::ROW_BITS-1:0]  out_line_top,
  input  logic [lebm_pkg::HIST_BITS-1:0] out_line_bottom,
  input  logic [lebm_pkg::HIST_BITS-1:0] out_baseline_row,
  input  logic [lebm_pkg::BOX_W-1:0]     out_box_count,
  output int                             fails,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lebm_pkg::*;

  typedef struct {
    logic [ROW_BITS-1:0]  line_top;
    logic [HIST_BITS-1:0] line_bottom;
    logic [HIST_BITS-1:0] baseline_row;
    logic [BOX_W-1:0]     box_count;
  } line_summary_t;

  line_summary_t        expected_lines[$];
  logic [CNT_W-1:0]     row_count[HIST_DEPTH];
  logic [HIST_BITS-1:0] touched_rows[$];
  logic [ROW_BITS-1:0]  top_min;
  logic [HIST_BITS-1:0] bottom_max;
  logic [HIST_BITS-1:0] best_row;
  logic [CNT_W-1:0]     best_count;
  logic [BOX_W-1:0]     boxes_seen;

  task automatic open_line();
    top_min    = {ROW_BITS{1'b1}};
    bottom_max = '0;
    best_row   = '0;
    best_count = '0;
    boxes_seen = '0;
  endtask

  task automatic fold_box(input logic [ROW_BITS-1:0] top, input logic [ROW_BITS-1:0] height,
                          input logic last);
    logic [HIST_BITS-1:0] bottom;
    logic [CNT_W-1:0]     cnt;
    line_summary_t        summary;
    bottom = {1'b0, top} + {1'b0, height};
    if (top < top_min) top_min = top;
    if (bottom > bottom_max) bottom_max = bottom;
    cnt = row_count[bottom];
    if (cnt == '0) touched_rows = {touched_rows, bottom};
    if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
    row_count[bottom] = cnt;
    if (cnt > best_count || (cnt == best_count && bottom < best_row)) begin
      best_count = cnt;
      best_row   = bottom;
    end
    if (boxes_seen < MAX_BOXES) boxes_seen = boxes_seen + 1'b1;
    if (last) begin
      summary.line_top     = top_min;
      summary.line_bottom  = bottom_max;
      summary.baseline_row = best_row;
      summary.box_count    = boxes_seen;
      expected_lines = {expected_lines, summary};
      foreach (touched_rows[i]) row_count[touched_rows[i]] = '0;
      touched_rows.delete();
      open_line();
    end
  endtask

  always @(posedge clk) begin
    line_summary_t want;
    if (!rst_n) begin
      fails = 0;
      foreach (row_count[i]) row_count[i] = '0;
      touched_rows.delete();
      expected_lines.delete();
      open_line();
    end else begin
      if (out_valid) begin
        if (expected_lines.size() == 0) begin
          $error("result word with no line pending");
          fails++;
        end else begin
          want = expected_lines.pop_front();
          if (out_line_top !== want.line_top) begin
            $error("line_top: expected %0d, got %0d", want.line_top, out_line_top);
            fails++;
          end
          if (out_line_bottom !== want.line_bottom) begin
            $error("line_bottom: expected %0d, got %0d", want.line_bottom, out_line_bottom);
            fails++;
          end
          if (out_baseline_row !== want.baseline_row) begin
            $error("baseline_row: expected %0d, got %0d", want.baseline_row, out_baseline_row);
            fails++;
          end
          if (out_box_count !== want.box_count) begin
            $error("box_count: expected %0d, got %0d", want.box_count, out_box_count);
            fails++;
          end
        end
      end
      if (start && !busy) fold_box(in_box_top, in_box_height, in_last_box);
    end
    pending = expected_lines.size();
  end

endmodule

>>> tb/sv/line_extent_and_baseline_mode_tb.sv
// Top of the line extent and baseline testbench: clock, reset, box stimulus and verdict.
module line_extent_and_baseline_mode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lebm_pkg::*;

  localparam int STALL_LIMIT = 40000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [ROW_BITS-1:0]  in_box_top;
  logic [ROW_BITS-1:0]  in_box_height;
  logic                 in_last_box;
  logic                 out_valid;
  logic [ROW_BITS-1:0]  out_line_top;
  logic [HIST_BITS-1:0] out_line_bottom;
  logic [HIST_BITS-1:0] out_baseline_row;
  logic [BOX_W-1:0]     out_box_count;
  int                   fails;
  int                   pending;
  int                   stall_cycles;
  int                   boxes_sent;
  int                   lines_sent;

  line_extent_and_baseline_mode dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_box_top       (in_box_top),
    .in_box_height    (in_box_height),
    .in_last_box      (in_last_box),
    .out_valid        (out_valid),
    .out_line_top     (out_line_top),
    .out_line_bottom  (out_line_bottom),
    .out_baseline_row (out_baseline_row),
    .out_box_count    (out_box_count)
  );

  line_summary_compare u_compare (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_box_top       (in_box_top),
    .in_box_height    (in_box_height),
    .in_last_box      (in_last_box),
    .out_valid        (out_valid),
    .out_line_top     (out_line_top),
    .out_line_bottom  (out_line_bottom),
    .out_baseline_row (out_baseline_row),
    .out_box_count    (out_box_count),
    .fails            (fails),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("line_extent_and_baseline_mode_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : int'($urandom_range(0, 14));
  endfunction

  // pick a top/height pair whose bottom lands on the given row
  task automatic aim_bottom(input int bottom, output int top, output int height);
    int lo;
    int hi;
    lo     = (bottom > 4095) ? bottom - 4095 : 0;
    hi     = (bottom < 4095) ? bottom : 4095;
    top    = $urandom_range(lo, hi);
    height = bottom - top;
  endtask

  task automatic send_box(input int top, input int height, input bit last, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         = 1'b1;
    in_box_top    = ROW_BITS'(top);
    in_box_height = ROW_BITS'(height);
    in_last_box   = last;
    do @(posedge clk); while (busy);
    boxes_sent++;
    if (last) lines_sent++;
  endtask

  initial begin
    int top;
    int height;
    int len;
    int mode;
    int base;
    int pick;
    bit burst;
    boxes_sent    = 0;
    lines_sent    = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_box_top    = '0;
    in_box_height = '0;
    in_last_box   = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_box(0, 0, 1'b1, draw_gap(1'b0));
    send_box(4095, 4095, 1'b1, draw_gap(1'b0));
    send_box(4095, 0, 1'b0, draw_gap(1'b0));
    send_box(0, 4095, 1'b0, draw_gap(1'b0));
    send_box(100, 0, 1'b0, 0);
    send_box(50, 50, 1'b1, 0);
    send_box(10, 90, 1'b0, draw_gap(1'b0));
    send_box(0, 50, 1'b0, draw_gap(1'b0));
    send_box(200, 100, 1'b1, draw_gap(1'b0));
    send_box(12'hAAA, 12'h555, 1'b0, draw_gap(1'b0));
    send_box(12'h555, 12'hAAA, 1'b1, draw_gap(1'b0));
    send_box(1, 1, 1'b0, 0);
    send_box(0, 2, 1'b0, 0);
    send_box(2, 0, 1'b1, 0);
    send_box(3000, 4095, 1'b0, draw_gap(1'b0));
    send_box(4095, 3000, 1'b1, 0);

    // tie two rows at equal counts, larger row first
    for (int i = 0; i < 60; i++) begin
      aim_bottom(200, top, height);
      send_box(top, height, 1'b0, 0);
    end
    for (int i = 0; i < 60; i++) begin
      aim_bottom(100, top, height);
      send_box(top, height, i == 59, 0);
    end

    // single-box lines on a few rows, enough to roll the line tag over
    for (int i = 0; i < 260; i++) begin
      aim_bottom(300 + $urandom_range(0, 3), top, height);
      send_box(top, height, 1'b1, draw_gap($urandom_range(0, 1) == 0));
    end

    while (boxes_sent < 700 || lines_sent < 300) begin
      pick  = $urandom_range(0, 9);
      len   = (pick < 4) ? 1 : (pick < 7) ? $urandom_range(2, 4) :
              (pick < 9) ? $urandom_range(5, 12) : $urandom_range(13, 40);
      mode  = $urandom_range(0, 3);
      base  = $urandom_range(0, 8188);
      burst = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < len; i++) begin
        if (mode == 0 || $urandom_range(0, 3) == 0) begin
          top    = $urandom_range(0, 4095);
          height = $urandom_range(0, 4095);
        end else begin
          aim_bottom(base + $urandom_range(0, 2), top, height);
        end
        send_box(top, height, i == len - 1, draw_gap(burst));
      end
    end

    @(negedge clk);
    start = 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("line_extent_and_baseline_mode_tb: clean");
    end else begin
      $display("line_extent_and_baseline_mode_tb: errors");
    end
    $finish;
  end

endmodule
